### design/rsl_pkg.sv
// Shared constants, types and derived widths for the radial spotlight luma pipeline.
`default_nettype none
package rsl_pkg;

    // Field widths
    localparam int COORD_BITS     = 12;
    localparam int LUMA_BITS      = 16;
    localparam int DIST_FRAC_BITS = 8;
    localparam int CENTER_BITS    = 13;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y = 2'd1;

    // Offset and distance geometry
    localparam int DIFF_BITS = COORD_BITS + 2;           // pixel minus center, signed
    localparam int FAR_DIST  = 160;
    localparam int OFF_BITS  = $clog2(FAR_DIST);         // offsets below FAR_DIST
    localparam int SQ_BITS   = 2 * OFF_BITS;             // 2 * 159^2 fits

    // Square root: radicand is the squared distance scaled by 2^(2F)
    localparam int RAD_BITS        = SQ_BITS + 2 * DIST_FRAC_BITS;
    localparam int ROOT_BITS       = RAD_BITS / 2;
    localparam int REM_BITS        = ROOT_BITS + 2;
    localparam int STEPS_PER_STAGE = 2;
    localparam int SQRT_STAGES     = ROOT_BITS / STEPS_PER_STAGE;

    // Dimming factor, in units of 1 / NEAR_DENOM
    localparam int FACTOR_BITS = ROOT_BITS;
    localparam logic [FACTOR_BITS-1:0] NEAR_DENOM = FACTOR_BITS'(200 << DIST_FRAC_BITS);
    localparam logic [FACTOR_BITS-1:0] FAR_FACTOR = FACTOR_BITS'((200 << DIST_FRAC_BITS) / 5);
    localparam logic [ROOT_BITS-1:0]   FAR_Q      = ROOT_BITS'(FAR_DIST << DIST_FRAC_BITS);

    // Divide by NEAR_DENOM = 2^SCALE_SHIFT * DIV_ODD
    localparam int PROD_BITS   = LUMA_BITS + FACTOR_BITS;
    localparam int SCALE_SHIFT = DIST_FRAC_BITS + 3;
    localparam longint unsigned DIV_ODD = (200 << DIST_FRAC_BITS) >> SCALE_SHIFT;
    localparam int N_BITS      = PROD_BITS - SCALE_SHIFT;
    localparam int RECIP_SHIFT = N_BITS + $clog2(DIV_ODD);
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << RECIP_SHIFT) + DIV_ODD - 64'd1) / DIV_ODD;
    localparam int RECIP_BITS  = $clog2(RECIP_VAL + 1);
    localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_VAL);
    localparam int QPROD_BITS  = N_BITS + RECIP_BITS;

    // Sideband that travels with each word through the pipeline
    typedef struct packed {
        logic                 far_off;
        logic [LUMA_BITS-1:0] luma;
    } side_t;

endpackage
`default_nettype wire

### design/rsl_offset.sv
// Front end: offsets from the center, their magnitudes and the squared distance.
`default_nettype none
module rsl_offset (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic [rsl_pkg::COORD_BITS-1:0]     pixel_x,
    input  wire logic [rsl_pkg::COORD_BITS-1:0]     pixel_y,
    input  wire logic [rsl_pkg::LUMA_BITS-1:0]      luma_in,
    input  wire logic signed [rsl_pkg::CENTER_BITS-1:0] center_x,
    input  wire logic signed [rsl_pkg::CENTER_BITS-1:0] center_y,
    output logic                                    out_valid,
    output logic [rsl_pkg::SQ_BITS-1:0]             sq,
    output rsl_pkg::side_t                          out_side
);
    import rsl_pkg::*;

    logic signed [DIFF_BITS-1:0] dx;
    logic signed [DIFF_BITS-1:0] dy;
    logic [DIFF_BITS-1:0]        abs_x;
    logic [DIFF_BITS-1:0]        abs_y;

    logic                  a_valid_reg;
    logic [OFF_BITS-1:0]   ax_reg;
    logic [OFF_BITS-1:0]   ay_reg;
    side_t                 a_side_reg;
    side_t                 a_side_next;

    logic                  b_valid_reg;
    logic [SQ_BITS-1:0]    sq_reg;
    logic [SQ_BITS-1:0]    sq_next;
    side_t                 b_side_reg;

    // Signed offsets and magnitudes; large offsets go straight to the far branch
    always_comb
    begin
        dx = $signed({2'b00, pixel_x}) - DIFF_BITS'(center_x);
        dy = $signed({2'b00, pixel_y}) - DIFF_BITS'(center_y);
        abs_x = dx[DIFF_BITS-1] ? DIFF_BITS'(-dx) : DIFF_BITS'(dx);
        abs_y = dy[DIFF_BITS-1] ? DIFF_BITS'(-dy) : DIFF_BITS'(dy);
        a_side_next.luma    = luma_in;
        a_side_next.far_off = (abs_x >= DIFF_BITS'(FAR_DIST)) ||
                              (abs_y >= DIFF_BITS'(FAR_DIST));
    end

    // Sum of squares of the truncated offsets
    always_comb
    begin
        sq_next = SQ_BITS'(ax_reg * ax_reg) + SQ_BITS'(ay_reg * ay_reg);
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        ax_reg     <= abs_x[OFF_BITS-1:0];
        ay_reg     <= abs_y[OFF_BITS-1:0];
        a_side_reg <= a_side_next;
        sq_reg     <= sq_next;
        b_side_reg <= a_side_reg;
    end

    assign out_valid = b_valid_reg;
    assign sq        = sq_reg;
    assign out_side  = b_side_reg;

endmodule
`default_nettype wire

### design/rsl_sqrt_stage.sv
// One pipeline stage of the digit-by-digit square root: two root bits per stage.
`default_nettype none
module rsl_sqrt_stage (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [rsl_pkg::RAD_BITS-1:0]  in_rad,
    input  wire logic [rsl_pkg::REM_BITS-1:0]  in_rem,
    input  wire logic [rsl_pkg::ROOT_BITS-1:0] in_root,
    input  wire rsl_pkg::side_t                in_side,
    output logic                               out_valid,
    output logic [rsl_pkg::RAD_BITS-1:0]       out_rad,
    output logic [rsl_pkg::REM_BITS-1:0]       out_rem,
    output logic [rsl_pkg::ROOT_BITS-1:0]      out_root,
    output rsl_pkg::side_t                     out_side
);
    import rsl_pkg::*;

    logic [RAD_BITS-1:0]  rad_next;
    logic [REM_BITS-1:0]  rem_next;
    logic [ROOT_BITS-1:0] root_next;
    logic [REM_BITS-1:0]  trial;

    logic                 valid_reg;
    logic [RAD_BITS-1:0]  rad_reg;
    logic [REM_BITS-1:0]  rem_reg;
    logic [ROOT_BITS-1:0] root_reg;
    side_t                side_reg;

    // Bring down two radicand bits, try root*4+1, keep the difference if it fits
    always_comb
    begin
        rad_next  = in_rad;
        rem_next  = in_rem;
        root_next = in_root;
        trial     = '0;
        for (int i = 0; i < STEPS_PER_STAGE; i++)
        begin
            rem_next = {rem_next[REM_BITS-3:0], rad_next[RAD_BITS-1 -: 2]};
            rad_next = {rad_next[RAD_BITS-3:0], 2'b00};
            trial    = {root_next, 2'b01};
            if (rem_next >= trial)
            begin
                rem_next  = rem_next - trial;
                root_next = {root_next[ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                root_next = {root_next[ROOT_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule
`default_nettype wire

### design/rsl_scale.sv
// Back end: dimming factor from the distance, luma product and exact divide.
`default_nettype none
module rsl_scale (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [rsl_pkg::ROOT_BITS-1:0] dist_q,
    input  wire rsl_pkg::side_t                in_side,
    output logic                               out_valid,
    output logic [rsl_pkg::LUMA_BITS-1:0]      luma_out
);
    import rsl_pkg::*;

    logic                   c_valid_reg;
    logic [FACTOR_BITS-1:0] factor_reg;
    logic [FACTOR_BITS-1:0] factor_next;
    logic [LUMA_BITS-1:0]   luma_reg;

    logic                   d_valid_reg;
    logic [PROD_BITS-1:0]   prod_reg;

    logic                   e_valid_reg;
    logic [QPROD_BITS-1:0]  qprod_reg;
    logic [N_BITS-1:0]      scaled;

    // Far branch uses 0.2, i.e. NEAR_DENOM / 5; near branch 1 - 0.005 d
    always_comb
    begin
        if (in_side.far_off || (dist_q >= FAR_Q))
            factor_next = FAR_FACTOR;
        else
            factor_next = NEAR_DENOM - dist_q;
    end

    // Power-of-two part of the denominator drops out as a shift
    assign scaled = prod_reg[PROD_BITS-1:SCALE_SHIFT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= in_valid;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    // Factor, luma product, then multiply by the rounded-up reciprocal of the odd part
    always_ff @(posedge clk)
    begin
        factor_reg <= factor_next;
        luma_reg   <= in_side.luma;
        prod_reg   <= PROD_BITS'(luma_reg * factor_reg);
        qprod_reg  <= QPROD_BITS'(scaled * RECIP);
    end

    assign out_valid = e_valid_reg;
    assign luma_out  = qprod_reg[RECIP_SHIFT +: LUMA_BITS];

endmodule
`default_nettype wire

### design/radial_spotlight_luma_core.sv
// Top level of the radial spotlight luma dimmer: config registers and pipeline.
//
// Usage:
//   Pixel channel: drive pixel_x, pixel_y and luma_in with start high; a word
//   is taken at every rising edge where start is high and busy is low. busy
//   is held low, so one pixel can be taken every clock.
//   Result channel: luma_out is shown for one cycle with done high. The
//   receiver cannot stall, and none is needed: nothing ever backs up.
//   Config channel: cfg_index 0 writes center_x, 1 writes center_y, any other
//   index is dropped. cfg_ready is always high; write only while no pixel is
//   in flight.
//   Pipeline: throughput one pixel per clock. Depth is set by the square
//   root, two root bits per stage over eight stages, plus two front-end
//   stages and three stages for factor, product and reciprocal divide.
//   Reset: clears the center to (0, 0) and all valid bits; no result appears
//   until a pixel is accepted after reset.
`default_nettype none
module radial_spotlight_luma_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [rsl_pkg::COORD_BITS-1:0]        pixel_x,
    input  wire logic [rsl_pkg::COORD_BITS-1:0]        pixel_y,
    input  wire logic [rsl_pkg::LUMA_BITS-1:0]         luma_in,
    output logic                                       done,
    output logic [rsl_pkg::LUMA_BITS-1:0]              luma_out,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [rsl_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  wire logic [rsl_pkg::CENTER_BITS-1:0]       cfg_data
);
    import rsl_pkg::*;

    logic signed [CENTER_BITS-1:0] center_x_reg;
    logic signed [CENTER_BITS-1:0] center_y_reg;

    logic               front_valid;
    logic [SQ_BITS-1:0] front_sq;
    side_t              front_side;

    logic                 chain_valid [SQRT_STAGES+1];
    logic [RAD_BITS-1:0]  chain_rad   [SQRT_STAGES+1];
    logic [REM_BITS-1:0]  chain_rem   [SQRT_STAGES+1];
    logic [ROOT_BITS-1:0] chain_root  [SQRT_STAGES+1];
    side_t                chain_side  [SQRT_STAGES+1];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Offsets and squared distance
    rsl_offset u_offset (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .luma_in   (luma_in),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .out_valid (front_valid),
        .sq        (front_sq),
        .out_side  (front_side)
    );

    // Square root chain, radicand scaled by 2^(2F)
    assign chain_valid[0] = front_valid;
    assign chain_rad[0]   = {front_sq, (2 * DIST_FRAC_BITS)'(0)};
    assign chain_rem[0]   = '0;
    assign chain_root[0]  = '0;
    assign chain_side[0]  = front_side;

    for (genvar s = 0; s < SQRT_STAGES; s++)
    begin : g_sqrt
        rsl_sqrt_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[s]),
            .in_rad    (chain_rad[s]),
            .in_rem    (chain_rem[s]),
            .in_root   (chain_root[s]),
            .in_side   (chain_side[s]),
            .out_valid (chain_valid[s+1]),
            .out_rad   (chain_rad[s+1]),
            .out_rem   (chain_rem[s+1]),
            .out_root  (chain_root[s+1]),
            .out_side  (chain_side[s+1])
        );
    end

    // Factor, product and divide
    rsl_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[SQRT_STAGES]),
        .dist_q    (chain_root[SQRT_STAGES]),
        .in_side   (chain_side[SQRT_STAGES]),
        .out_valid (done),
        .luma_out  (luma_out)
    );

    // Final remainder and shifted-out radicand are not needed
    logic unused_tail;
    assign unused_tail = ^{chain_rad[SQRT_STAGES], chain_rem[SQRT_STAGES]};

endmodule
`default_nettype wire

### dv/rsl_luma_checker.sv
// Checker for the radial spotlight luma core: predicts each dimmed word and compares it.
`timescale 1ns / 100ps
module rsl_luma_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [rsl_pkg::COORD_BITS-1:0]    pixel_x,
    input  logic [rsl_pkg::COORD_BITS-1:0]    pixel_y,
    input  logic [rsl_pkg::LUMA_BITS-1:0]     luma_in,
    input  logic                              done,
    input  logic [rsl_pkg::LUMA_BITS-1:0]     luma_out,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [rsl_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [rsl_pkg::CENTER_BITS-1:0]   cfg_data,
    output int                                mismatches,
    output int                                pending
);

    // Spotlight geometry, distances carry DIST_FRAC_BITS fraction bits
    localparam longint unsigned SPOT_RADIUS = 160;
    localparam longint unsigned RADIUS_Q    = SPOT_RADIUS << rsl_pkg::DIST_FRAC_BITS;
    localparam longint unsigned FULL_SCALE  = 64'd200 << rsl_pkg::DIST_FRAC_BITS;
    localparam longint unsigned FAR_DIVISOR = 5;

    logic signed [rsl_pkg::CENTER_BITS-1:0] spot_cx;
    logic signed [rsl_pkg::CENTER_BITS-1:0] spot_cy;
    logic [rsl_pkg::LUMA_BITS-1:0]          luma_want;
    logic [rsl_pkg::LUMA_BITS-1:0]          luma_due_q[$];

    // Dimmed luminance for one pixel against the given center
    function automatic logic [rsl_pkg::LUMA_BITS-1:0] dimmed_luma(
        input logic [rsl_pkg::COORD_BITS-1:0]          px,
        input logic [rsl_pkg::COORD_BITS-1:0]          py,
        input logic [rsl_pkg::LUMA_BITS-1:0]           luma,
        input logic signed [rsl_pkg::CENTER_BITS-1:0]  cx,
        input logic signed [rsl_pkg::CENTER_BITS-1:0]  cy
    );
        longint          off_x;
        longint          off_y;
        longint unsigned radicand;
        longint unsigned root;
        longint unsigned trial;
        longint unsigned scaled;
        off_x = longint'(px) - longint'(cx);
        off_y = longint'(py) - longint'(cy);
        if (off_x < 0)
            off_x = -off_x;
        if (off_y < 0)
            off_y = -off_y;
        // either axis at the radius or beyond: always the far factor
        if (off_x >= longint'(SPOT_RADIUS) || off_y >= longint'(SPOT_RADIUS))
            return rsl_pkg::LUMA_BITS'(longint'(luma) / FAR_DIVISOR);
        radicand = longint'(off_x * off_x + off_y * off_y) << (2 * rsl_pkg::DIST_FRAC_BITS);
        // bitwise search for floor(sqrt(radicand))
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand)
                root = trial;
        end
        if (root >= RADIUS_Q)
            return rsl_pkg::LUMA_BITS'(longint'(luma) / FAR_DIVISOR);
        scaled = longint'(luma) * (FULL_SCALE - root);
        return rsl_pkg::LUMA_BITS'(scaled / FULL_SCALE);
    endfunction

    // Track center writes, queue predictions, compare each done word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spot_cx    <= '0;
            spot_cy    <= '0;
            mismatches <= 0;
            pending    <= 0;
            luma_due_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (luma_due_q.size() == 0)
                begin
                    $error("luma_out: no word expected, actual %0d", luma_out);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    luma_want = luma_due_q.pop_front();
                    if (luma_out !== luma_want)
                    begin
                        $error("luma_out: expected %0d, actual %0d", luma_want, luma_out);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (start && !busy)
                luma_due_q.push_back(dimmed_luma(pixel_x, pixel_y, luma_in, spot_cx, spot_cy));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rsl_pkg::REG_CENTER_X: spot_cx <= cfg_data;
                    rsl_pkg::REG_CENTER_Y: spot_cy <= cfg_data;
                    default: ;
                endcase
            end
            pending <= luma_due_q.size();
        end
    end

endmodule

### dv/tb_radial_spotlight_luma_core.sv
// Testbench top for the radial spotlight luma core: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module tb_radial_spotlight_luma_core;

    localparam int PIPE_LATENCY  = 13;
    localparam int QUIET_LIMIT   = 400;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 160;
    localparam int COORD_MAX     = (1 << rsl_pkg::COORD_BITS) - 1;
    localparam int LUMA_MAX      = (1 << rsl_pkg::LUMA_BITS) - 1;
    localparam int CENTER_MIN    = -(1 << (rsl_pkg::CENTER_BITS - 1));
    localparam int CENTER_MAX    = (1 << (rsl_pkg::CENTER_BITS - 1)) - 1;
    // unused register slots, writes there must be dropped
    localparam logic [rsl_pkg::CFG_IDX_BITS-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [rsl_pkg::CFG_IDX_BITS-1:0] REG_SPARE_3 = 2'd3;

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic [rsl_pkg::COORD_BITS-1:0]     pixel_x;
    logic [rsl_pkg::COORD_BITS-1:0]     pixel_y;
    logic [rsl_pkg::LUMA_BITS-1:0]      luma_in;
    logic                               done;
    logic [rsl_pkg::LUMA_BITS-1:0]      luma_out;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [rsl_pkg::CFG_IDX_BITS-1:0]   cfg_index;
    logic [rsl_pkg::CENTER_BITS-1:0]    cfg_data;
    int                                 mismatches;
    int                                 pending;
    int                                 quiet_cycles;
    bit                                 idle_on;

    radial_spotlight_luma_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .luma_in   (luma_in),
        .done      (done),
        .luma_out  (luma_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rsl_luma_checker i_luma_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .luma_in    (luma_in),
        .done       (done),
        .luma_out   (luma_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: too many cycles with no word moving on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Offer one pixel, with an optional idle burst first; start stays high on return
    task automatic send_pixel(input int x, input int y, input int luma);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        start   <= 1'b1;
        pixel_x <= rsl_pkg::COORD_BITS'(x);
        pixel_y <= rsl_pkg::COORD_BITS'(y);
        luma_in <= rsl_pkg::LUMA_BITS'(luma);
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stop offering pixels and wait until every predicted word has come back
    task automatic drain_pipe();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // One register write; cfg_valid is left high for a following write
    task automatic cfg_word(input logic [rsl_pkg::CFG_IDX_BITS-1:0] idx, input int data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= rsl_pkg::CENTER_BITS'(data);
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Move the spotlight while idle; a write to a spare slot goes in between
    task automatic move_center(input int cx, input int cy);
        drain_pipe();
        cfg_word(rsl_pkg::REG_CENTER_X, cx);
        cfg_word($urandom_range(0, 1) ? REG_SPARE_3 : REG_SPARE_2,
                 int'($urandom_range(0, (1 << rsl_pkg::CENTER_BITS) - 1)));
        cfg_word(rsl_pkg::REG_CENTER_Y, cy);
        cfg_valid <= 1'b0;
    endtask

    // Random pixel: mostly close to the center so the near branch is busy
    task automatic send_random(input int cx, input int cy);
        int x;
        int y;
        int luma;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            x = $urandom_range(0, COORD_MAX);
            y = $urandom_range(0, COORD_MAX);
        end
        else
        begin
            x = cx + int'($urandom_range(0, 340)) - 170;
            y = cy + int'($urandom_range(0, 340)) - 170;
            x = (x < 0) ? 0 : (x > COORD_MAX) ? COORD_MAX : x;
            y = (y < 0) ? 0 : (y > COORD_MAX) ? COORD_MAX : y;
        end
        pick = $urandom_range(0, 9);
        if (pick == 0)
            luma = LUMA_MAX;
        else if (pick == 1)
            luma = 0;
        else
            luma = $urandom_range(0, LUMA_MAX);
        send_pixel(x, y, luma);
    endtask

    // Stimulus
    initial
    begin
        int cx;
        int cy;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        pixel_x   <= '0;
        pixel_y   <= '0;
        luma_in   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= rsl_pkg::REG_CENTER_X;
        cfg_data  <= '0;
        idle_on   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: center at reset value (0, 0)
        send_pixel(0, 0, LUMA_MAX);          // zero distance, factor one
        send_pixel(0, 0, 0);
        send_pixel(0, 0, 1);
        send_pixel(1, 0, LUMA_MAX);          // smallest nonzero distance
        send_pixel(96, 128, LUMA_MAX);       // distance exactly on the radius
        send_pixel(160, 0, LUMA_MAX);        // one axis at the radius
        send_pixel(0, 159, LUMA_MAX);        // just inside along an axis
        send_pixel(112, 113, 54321);         // just inside on a diagonal
        send_pixel(159, 159, LUMA_MAX);      // both axes inside, distance beyond
        send_pixel(COORD_MAX, COORD_MAX, LUMA_MAX);
        send_pixel(COORD_MAX, 0, 12345);

        // Directed: center at the register extremes
        move_center(CENTER_MIN, CENTER_MAX);
        send_pixel(0, COORD_MAX, LUMA_MAX);
        send_pixel(COORD_MAX, 0, LUMA_MAX);
        move_center(CENTER_MAX, CENTER_MIN);
        send_pixel(COORD_MAX, 0, LUMA_MAX);
        send_pixel(0, COORD_MAX, 40000);
        move_center(COORD_MAX, COORD_MAX);
        send_pixel(COORD_MAX, COORD_MAX, LUMA_MAX);
        send_pixel(4000, COORD_MAX, LUMA_MAX);
        send_pixel(COORD_MAX, 3936, 65534);
        send_pixel(3999, 3999, LUMA_MAX);

        // Random phases, each with a fresh center; the third, sixth and last run without gaps
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
            begin
                cx = CENTER_MIN;
                cy = CENTER_MIN;
            end
            else if (p == 1)
            begin
                cx = CENTER_MAX;
                cy = CENTER_MAX;
            end
            else
            begin
                cx = int'($urandom_range(0, 4495)) - 200;
                cy = int'($urandom_range(0, 4495)) - 200;
                cx = (cx > CENTER_MAX) ? CENTER_MAX : cx;
                cy = (cy > CENTER_MAX) ? CENTER_MAX : cy;
            end
            move_center(cx, cy);
            idle_on = (p != RANDOM_PHASES - 1) && (p % 3 != 2);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // hold off once mid-phase until the pipe is empty
                if (p == 3 && n == PHASE_WORDS / 2)
                    drain_pipe();
                send_random(cx, cy);
            end
        end

        // Wrap-up
        drain_pipe();
        repeat (PIPE_LATENCY + 4) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
